[hw/rtl/erv_pkg.sv]
// ----------------------------------------------------------------------------
// erv_pkg: shared types and constants for the Euler rotation block
// Field widths, the transfer payload structs and the classified item passed
// from the front end to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package erv_pkg;

  localparam int COORD_BITS  = 32;
  localparam int ANGLE_BITS  = 16;
  localparam int SPLIT_BITS  = 24;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic signed [COORD_BITS-1:0] in_z;
    logic signed [ANGLE_BITS-1:0] angle_a;
    logic signed [ANGLE_BITS-1:0] angle_b;
    logic signed [ANGLE_BITS-1:0] angle_c;
  } erv_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         clipped;
  } erv_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } erv_vec_t;

  // Angle split into quadrant and Q0.30 fraction of the quadrant.
  typedef struct packed {
    logic [1:0]  quad;
    logic [29:0] frac;
  } erv_ang_t;

  typedef struct packed {
    erv_vec_t vec;
    erv_ang_t ang_a;
    erv_ang_t ang_b;
    erv_ang_t ang_c;
  } erv_cls_t;

endpackage

`default_nettype wire

[hw/rtl/erv_fifo.sv]
// ----------------------------------------------------------------------------
// erv_fifo: small register queue
// Decouples the front end from the datapath; fall-through read.
// ----------------------------------------------------------------------------
`default_nettype none

module erv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + CW'(1))
    else $error("queue count missed a write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - CW'(1))
    else $error("queue count missed a read");

endmodule

`default_nettype wire

[hw/rtl/erv_front.sv]
// ----------------------------------------------------------------------------
// erv_front: input stage
// Registers each item and splits its angles into quadrant and fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module erv_front import erv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  erv_in_t  in_data_i,
  output logic     cls_valid_o,
  input  logic     cls_ready_i,
  output erv_cls_t cls_data_o
);

  function automatic erv_ang_t classify(input logic [ANGLE_BITS-1:0] a);
    erv_ang_t r;
    r.quad = a[ANGLE_BITS-1:ANGLE_BITS-2];
    r.frac = {a[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};
    return r;
  endfunction

  logic     vld_q;
  erv_cls_t data_q;

  assign in_ready_o  = !vld_q || cls_ready_i;
  assign cls_valid_o = vld_q;
  assign cls_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q.vec.x <= in_data_i.in_x;
      data_q.vec.y <= in_data_i.in_y;
      data_q.vec.z <= in_data_i.in_z;
      data_q.ang_a <= classify(in_data_i.angle_a);
      data_q.ang_b <= classify(in_data_i.angle_b);
      data_q.ang_c <= classify(in_data_i.angle_c);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/erv_sincos.sv]
// ----------------------------------------------------------------------------
// erv_sincos: pipelined sine and cosine
// Eight stages: square, five Horner steps, final product, quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module erv_sincos import erv_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  erv_ang_t           ang_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam logic [30:0] SINE_K [6] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026996, 31'd172272, 31'd3864
  };
  localparam logic [30:0] ONE = 31'd1 << 30;

  // Index 0 evaluates S(f), index 1 evaluates S(1 - f).
  logic [1:0]  quad_q [7];
  logic [30:0] u_q    [6][2];
  logic [30:0] w_q    [5][2];
  logic [61:0] prod_q [7][2];
  logic [30:0] u_in   [2];
  logic [61:0] sq     [2];
  logic [30:0] pin    [7][2];
  logic [31:0] s_full [2];
  logic [31:0] s_val  [2];

  always_comb begin
    u_in[0] = {1'b0, ang_i.frac};
    u_in[1] = ONE - {1'b0, ang_i.frac};
    for (int k = 0; k < 2; k++) begin
      sq[k] = u_in[k] * u_in[k];
      pin[0][k] = '0;
      pin[1][k] = SINE_K[5];
      for (int s = 2; s < 7; s++) begin
        pin[s][k] = SINE_K[6 - s] - prod_q[s - 1][k][60:30];
      end
      s_full[k] = prod_q[6][k][61:30];
      s_val[k]  = (s_full[k] > {1'b0, ONE}) ? {1'b0, ONE} : s_full[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= ang_i.quad;
      for (int s = 1; s < 7; s++) begin
        quad_q[s] <= quad_q[s - 1];
      end
      for (int k = 0; k < 2; k++) begin
        u_q[0][k] <= u_in[k];
        for (int s = 1; s < 6; s++) begin
          u_q[s][k] <= u_q[s - 1][k];
        end
        w_q[0][k] <= sq[k][60:30];
        for (int s = 1; s < 5; s++) begin
          w_q[s][k] <= w_q[s - 1][k];
        end
        for (int s = 1; s < 6; s++) begin
          prod_q[s][k] <= pin[s][k] * w_q[s - 1][k];
        end
        prod_q[6][k] <= pin[6][k] * u_q[5][k];
      end
      case (quad_q[6])
        2'd0: begin
          sin_o <= s_val[0];
          cos_o <= s_val[1];
        end
        2'd1: begin
          sin_o <= s_val[1];
          cos_o <= -s_val[0];
        end
        2'd2: begin
          sin_o <= -s_val[0];
          cos_o <= -s_val[1];
        end
        default: begin
          sin_o <= -s_val[1];
          cos_o <= s_val[0];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/erv_back.sv]
// ----------------------------------------------------------------------------
// erv_back: rotation datapath
// Trig, matrix build and the rounded, saturated matrix-vector product.
// ----------------------------------------------------------------------------
`default_nettype none

module erv_back import erv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cls_valid_i,
  output logic     cls_ready_o,
  input  erv_cls_t cls_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output erv_out_t out_data_o
);

  localparam int NST  = 16;
  localparam int HI_W = (COORD_BITS > SPLIT_BITS) ? COORD_BITS - SPLIT_BITS : 1;
  localparam int VX_W = COORD_BITS + SPLIT_BITS;
  localparam int HS_W = HI_W + 36;
  localparam int LS_W = SPLIT_BITS + 37;
  localparam int TW   = HS_W + SPLIT_BITS + 1;
  localparam int RW   = TW - 30;
  localparam logic signed [65:0]   QHALF   = 66'sd1 <<< 29;
  localparam logic signed [TW-1:0] RHALF   = TW'(64'sd1 <<< 29);
  localparam logic signed [RW-1:0] SAT_MAX = RW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_MIN = -SAT_MAX - RW'(1);

  function automatic logic signed [33:0] qmul(input logic signed [65:0] p);
    logic signed [65:0] t;
    if (!p[65]) begin
      t = (p + QHALF) >>> 30;
    end else begin
      t = -((-p + QHALF) >>> 30);
    end
    return t[33:0];
  endfunction

  logic [NST-1:0] vld_q;
  logic           en;
  erv_vec_t       cd_q [12];

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign cls_ready_o = en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], cls_valid_i};
    end
  end

  logic signed [31:0] sa, ca, sb, cb, sc, cc;

  erv_sincos u_trig_a (.clk_i, .en_i(en), .ang_i(cls_data_i.ang_a), .sin_o(sa), .cos_o(ca));
  erv_sincos u_trig_b (.clk_i, .en_i(en), .ang_i(cls_data_i.ang_b), .sin_o(sb), .cos_o(cb));
  erv_sincos u_trig_c (.clk_i, .en_i(en), .ang_i(cls_data_i.ang_c), .sin_o(sc), .cos_o(cc));

  // Products of the first level, then rounded.
  logic signed [65:0] p_casb, p_sasb, p_cacb, p_sacb, p_sacc, p_sasc, p_cacc, p_casc;
  logic signed [65:0] p_cbsc, p_cbcc;
  logic signed [31:0] sb1_q, sc1_q, cc1_q, sb2_q, sc2_q, cc2_q, sb3_q;
  logic signed [33:0] r_casb, r_sasb, r_cacb, r_sacb, r_sacc, r_sasc, r_cacc, r_casc;
  logic signed [33:0] r_cbsc, r_cbcc;
  logic signed [33:0] q_cacb, q_sacb, q_sacc, q_sasc, q_cacc, q_casc, q_cbsc, q_cbcc;
  logic signed [65:0] p2_casbsc, p2_casbcc, p2_sasbsc, p2_sasbcc;
  logic signed [33:0] m_q [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_casb <= ca * sb;
      p_sasb <= sa * sb;
      p_cacb <= ca * cb;
      p_sacb <= sa * cb;
      p_sacc <= sa * cc;
      p_sasc <= sa * sc;
      p_cacc <= ca * cc;
      p_casc <= ca * sc;
      p_cbsc <= cb * sc;
      p_cbcc <= cb * cc;
      sb1_q  <= sb;
      sc1_q  <= sc;
      cc1_q  <= cc;

      r_casb <= qmul(p_casb);
      r_sasb <= qmul(p_sasb);
      r_cacb <= qmul(p_cacb);
      r_sacb <= qmul(p_sacb);
      r_sacc <= qmul(p_sacc);
      r_sasc <= qmul(p_sasc);
      r_cacc <= qmul(p_cacc);
      r_casc <= qmul(p_casc);
      r_cbsc <= qmul(p_cbsc);
      r_cbcc <= qmul(p_cbcc);
      sb2_q  <= sb1_q;
      sc2_q  <= sc1_q;
      cc2_q  <= cc1_q;

      p2_casbsc <= r_casb * sc2_q;
      p2_casbcc <= r_casb * cc2_q;
      p2_sasbsc <= r_sasb * sc2_q;
      p2_sasbcc <= r_sasb * cc2_q;
      q_cacb <= r_cacb;
      q_sacb <= r_sacb;
      q_sacc <= r_sacc;
      q_sasc <= r_sasc;
      q_cacc <= r_cacc;
      q_casc <= r_casc;
      q_cbsc <= r_cbsc;
      q_cbcc <= r_cbcc;
      sb3_q  <= sb2_q;

      m_q[0] <= q_cacb;
      m_q[1] <= 34'(qmul(p2_casbsc) - q_sacc);
      m_q[2] <= 34'(qmul(p2_casbcc) + q_sasc);
      m_q[3] <= q_sacb;
      m_q[4] <= 34'(qmul(p2_sasbsc) + q_cacc);
      m_q[5] <= 34'(qmul(p2_sasbcc) - q_casc);
      m_q[6] <= -34'(sb3_q);
      m_q[7] <= q_cbsc;
      m_q[8] <= q_cbcc;

      cd_q[0] <= cls_data_i.vec;
      for (int s = 1; s < 12; s++) begin
        cd_q[s] <= cd_q[s - 1];
      end
    end
  end

  // Dot products: each coordinate split into a signed high part and an
  // unsigned low part so that no multiplier grows past the matrix width.
  logic signed [COORD_BITS-1:0] coord [3];
  logic        [VX_W-1:0]       vx    [3];
  logic signed [HI_W-1:0]       vh    [3];
  logic        [SPLIT_BITS-1:0] vl    [3];
  logic signed [HI_W+33:0]      ph_q  [3][3];
  logic signed [SPLIT_BITS+34:0] pl_q [3][3];
  logic signed [HS_W-1:0]       hs_q  [3];
  logic signed [LS_W-1:0]       ls_q  [3];
  logic signed [TW-1:0]         tot   [3];
  logic signed [RW-1:0]         res_q [3];
  logic signed [COORD_BITS-1:0] sat   [3];
  logic        [2:0]            clip;
  erv_out_t                     out_q;

  always_comb begin
    coord[0] = cd_q[11].x;
    coord[1] = cd_q[11].y;
    coord[2] = cd_q[11].z;
    for (int j = 0; j < 3; j++) begin
      vx[j] = {{SPLIT_BITS{coord[j][COORD_BITS-1]}}, coord[j]};
      vh[j] = $signed(vx[j][SPLIT_BITS+HI_W-1:SPLIT_BITS]);
      vl[j] = vx[j][SPLIT_BITS-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      tot[i] = (TW'(hs_q[i]) <<< SPLIT_BITS) + TW'(ls_q[i]) + RHALF;
      if (res_q[i] > SAT_MAX) begin
        sat[i]  = SAT_MAX[COORD_BITS-1:0];
        clip[i] = 1'b1;
      end else if (res_q[i] < SAT_MIN) begin
        sat[i]  = SAT_MIN[COORD_BITS-1:0];
        clip[i] = 1'b1;
      end else begin
        sat[i]  = res_q[i][COORD_BITS-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph_q[i][j] <= vh[j] * m_q[3*i + j];
          pl_q[i][j] <= $signed({1'b0, vl[j]}) * m_q[3*i + j];
        end
        hs_q[i]  <= HS_W'(ph_q[i][0]) + HS_W'(ph_q[i][1]) + HS_W'(ph_q[i][2]);
        ls_q[i]  <= LS_W'(pl_q[i][0]) + LS_W'(pl_q[i][1]) + LS_W'(pl_q[i][2]);
        res_q[i] <= tot[i][TW-1:30];
      end
      out_q.out_x   <= sat[0];
      out_q.out_y   <= sat[1];
      out_q.out_z   <= sat[2];
      out_q.clipped <= |clip;
    end
  end

  assign out_data_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      out_data_o.out_x == SAT_MAX[COORD_BITS-1:0] || out_data_o.out_x == SAT_MIN[COORD_BITS-1:0]
      || out_data_o.out_y == SAT_MAX[COORD_BITS-1:0]
      || out_data_o.out_y == SAT_MIN[COORD_BITS-1:0]
      || out_data_o.out_z == SAT_MAX[COORD_BITS-1:0]
      || out_data_o.out_z == SAT_MIN[COORD_BITS-1:0])
    else $error("clip flag without a saturated component");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_q))
    else $error("result lost while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> sb1_q <= 32'sd1073741824 && sb1_q >= -32'sd1073741824)
    else $error("sine out of unit range");

endmodule

`default_nettype wire

[hw/rtl/euler_rotate_vec3.sv]
// ----------------------------------------------------------------------------
// euler_rotate_vec3: ZYX Euler rotation of a Q16.16 point
// Rotates a point by Rz(a) * Ry(b) * Rx(c) with saturating output.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the input channel (in_valid_i, in_ready_o,
// in_data_i) as a point in signed Q16.16 and three binary angles, where half
// of the angle range is pi. Each item gives exactly one result on the output
// channel (out_valid_o, out_ready_i, out_data_o): the rotated point, rounded
// to nearest and clamped to the coordinate range, with clipped set when any
// component was clamped.
// Throughput is one transfer per cycle while results are taken. An item
// passes through the input register, the queue, the sine and cosine
// pipelines, the matrix build and the stages forming the rounded, saturated
// products, the last of which is the output register.
// The input register feeds a short queue; the datapath behind it advances
// whenever its output register is empty or being taken. When the receiver
// stalls the datapath holds, the queue fills, and only then is in_ready_o
// dropped. Reset empties every stage and the queue; no result is pending
// after reset and the block accepts an item in the first cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_rotate_vec3 import erv_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  erv_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output erv_out_t out_data_o
);

  // Front end to queue.
  logic     fr_valid, fr_ready;
  erv_cls_t fr_data;
  // Queue to datapath.
  logic     bk_valid, bk_ready;
  erv_cls_t bk_data;

  erv_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .cls_valid_o (fr_valid),
    .cls_ready_i (fr_ready),
    .cls_data_o  (fr_data)
  );

  erv_fifo #(
    .WIDTH ($bits(erv_cls_t)),
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_data),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_data)
  );

  erv_back u_back (
    .clk_i,
    .rst_ni,
    .cls_valid_i (bk_valid),
    .cls_ready_o (bk_ready),
    .cls_data_i  (bk_data),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression for euler_rotate_vec3
// Drives points and angles through the valid/ready input channel, predicts
// each rotated point with a fixed-point model kept in the testbench, and
// checks every output transfer in order under several idling phases.
// ----------------------------------------------------------------------------
module tb;
  import erv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q30_ONE  = 64'sd1 << 30;
  localparam longint Q30_HALF = 64'sd1 << 29;
  localparam int     NUM_RANDOM = 1950;
  localparam longint CYCLE_LIMIT = 400000;

  // Predicts rotated points and holds them until the block delivers them.
  class rotation_scoreboard;
    erv_out_t pending[$];
    int       mismatches;

    // Quarter-wave sine of a Q0.30 fraction in [0, 2^30].
    function automatic longint quarter_sine(longint u);
      longint terms[6];
      longint w, p, s;
      terms = '{1686629713, 693598668, 85569306, 5026996, 172272, 3864};
      w = (u * u) >>> 30;
      p = terms[5];
      for (int k = 4; k >= 0; k--) p = terms[k] - ((p * w) >>> 30);
      s = (u * p) >>> 30;
      if (s > Q30_ONE) s = Q30_ONE;
      return s;
    endfunction

    function automatic void sine_cosine(logic [ANGLE_BITS-1:0] ang,
                                        output longint sn, output longint cs);
      logic [31:0] phase;
      longint f, s0, c0;
      phase = {ang, {(32-ANGLE_BITS){1'b0}}};
      f = longint'(phase[29:0]);
      s0 = quarter_sine(f);
      c0 = quarter_sine(Q30_ONE - f);
      case (phase[31:30])
        2'd0: begin sn = s0;  cs = c0;  end
        2'd1: begin sn = c0;  cs = -s0; end
        2'd2: begin sn = -s0; cs = -c0; end
        default: begin sn = -c0; cs = s0; end
      endcase
    endfunction

    // Q2.30 product, rounded to nearest with ties away from zero.
    function automatic longint mul_q30(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return (p + Q30_HALF) >>> 30;
      return -((-p + Q30_HALF) >>> 30);
    endfunction

    // Exact 128-bit dot product, rounded half up, then saturated.
    function automatic logic signed [COORD_BITS-1:0] rotate_row(
        longint r0, longint r1, longint r2, erv_vec_t v, ref logic clip);
      logic signed [127:0] acc, res, lim;
      acc = 128'(r0) * 128'(v.x) + 128'(r1) * 128'(v.y) + 128'(r2) * 128'(v.z);
      res = (acc + 128'(Q30_HALF)) >>> 30;
      lim = 128'sd1 <<< (COORD_BITS - 1);
      if (res > lim - 1) begin
        clip = 1'b1;
        return {1'b0, {(COORD_BITS-1){1'b1}}};
      end else if (res < -lim) begin
        clip = 1'b1;
        return {1'b1, {(COORD_BITS-1){1'b0}}};
      end
      return res[COORD_BITS-1:0];
    endfunction

    function void note_input(erv_in_t item);
      longint sa, ca, sb, cb, sc, cc, casb, sasb;
      longint m[9];
      erv_vec_t v;
      erv_out_t exp_res;
      logic clip;
      sine_cosine(item.angle_a, sa, ca);
      sine_cosine(item.angle_b, sb, cb);
      sine_cosine(item.angle_c, sc, cc);
      casb = mul_q30(ca, sb);
      sasb = mul_q30(sa, sb);
      m[0] = mul_q30(ca, cb);
      m[1] = mul_q30(casb, sc) - mul_q30(sa, cc);
      m[2] = mul_q30(casb, cc) + mul_q30(sa, sc);
      m[3] = mul_q30(sa, cb);
      m[4] = mul_q30(sasb, sc) + mul_q30(ca, cc);
      m[5] = mul_q30(sasb, cc) - mul_q30(ca, sc);
      m[6] = -sb;
      m[7] = mul_q30(cb, sc);
      m[8] = mul_q30(cb, cc);
      v.x = item.in_x;
      v.y = item.in_y;
      v.z = item.in_z;
      clip = 1'b0;
      exp_res.out_x = rotate_row(m[0], m[1], m[2], v, clip);
      exp_res.out_y = rotate_row(m[3], m[4], m[5], v, clip);
      exp_res.out_z = rotate_row(m[6], m[7], m[8], v, clip);
      exp_res.clipped = clip;
      pending.push_back(exp_res);
    endfunction

    function void check_result(erv_out_t got);
      erv_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.clipped !== want.clipped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%0d y=%0d z=%0d clip=%0b got x=%0d y=%0d z=%0d clip=%0b",
                   want.out_x, want.out_y, want.out_z, want.clipped,
                   got.out_x, got.out_y, got.out_z, got.clipped);
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  erv_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  erv_out_t out_data_o;

  rotation_scoreboard board = new();

  // Percentage chances of idling on each side; the stimulus sets them per phase.
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_off = 1'b0;
  longint cycle_count = 0;

  euler_rotate_vec3 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog: a correct run finishes far inside this many cycles.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("euler_rotate_vec3 regression: fail");
      $finish;
    end
  end

  // Receiver side: ready is redrawn every cycle, and held low during a
  // hold-off so that the pipeline and its queue fill and input stalls.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Presents one item and waits for its transfer. Idle cycles come first,
  // so valid never drops between back-to-back transfers.
  task automatic send_point(erv_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(item);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(3))
      // Quadrant boundaries and their neighbours.
      0: return 16'($urandom_range(3) * 16384 + $urandom_range(2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic erv_in_t rand_point();
    erv_in_t item;
    item.in_x = rand_coord();
    item.in_y = rand_coord();
    item.in_z = rand_coord();
    item.angle_a = rand_angle();
    item.angle_b = rand_angle();
    item.angle_c = rand_angle();
    return item;
  endfunction

  task automatic drain_and_wait();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    erv_in_t item;
    logic [15:0] angs[6];
    logic [31:0] crds[4];
    angs = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h7fff, 16'h0001};
    crds = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_ffff};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme coordinates against the cardinal angles, which also
    // drives clamping in both directions; the last holds all-ones angles.
    for (int i = 0; i < 24; i++) begin
      item.in_x = crds[i % 4];
      item.in_y = crds[(i + 1) % 4];
      item.in_z = crds[(i / 4) % 4];
      item.angle_a = angs[i % 6];
      item.angle_b = angs[(i / 6) % 6];
      item.angle_c = angs[(i + 3) % 6];
      if (i == 23) begin
        item.in_x = 32'h7fff_ffff; item.in_y = 32'h7fff_ffff; item.in_z = 32'h7fff_ffff;
        item.angle_a = 16'hffff; item.angle_b = 16'hffff; item.angle_c = 16'hffff;
      end
      send_point(item);
    end

    // Random phases: none, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 83 : (ph == 3) ? 25 : 0;
      recv_stall_pct = (ph == 2) ? 83 : (ph == 3) ? 25 : 0;
      for (int n = 0; n < NUM_RANDOM / 4; n++) begin
        if (ph == 0 && n == 100) begin
          // Long receiver hold-off while the sender keeps offering items.
          fork
            begin
              hold_off = 1'b1;
              repeat (200) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        send_point(rand_point());
      end
    end
    in_valid_i <= 1'b0;

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_and_wait();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("euler_rotate_vec3 regression: pass");
    end else begin
      $display("euler_rotate_vec3 regression: fail");
    end
    $finish;
  end
endmodule
